@@ rtl/sorted_list_free_list_engine_macros.svh @@
// Assertion macros for the sorted list engine.
// Depends on nothing; included by the top level only.
`ifndef SORTED_LIST_FREE_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_FREE_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define SLFL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slfl assertion failed");

// next-cycle implication
`define SLFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slfl assertion failed");

`endif

@@ rtl/slfl_pkg.sv @@
// Shared types, codes and the control store of the sorted list engine.
// No dependencies; imported by every module of the block.
package slfl_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_WALK,
    OP_REPLY,
    OP_INS_A,
    OP_INS_B,
    OP_INS_C,
    OP_DEL_A,
    OP_DEL_B
  } op_t;

  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_NEVER,
    JC_CLR_LAST,
    JC_ACCEPT,
    JC_ADVANCE,
    JC_INS_OK,
    JC_DEL_OK,
    JC_TAKEN
  } cond_t;

  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 12;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_INIT    = 4'd0;
  localparam step_t S_IDLE    = 4'd1;
  localparam step_t S_WALK    = 4'd2;
  localparam step_t S_CHK_INS = 4'd3;
  localparam step_t S_CHK_DEL = 4'd4;
  localparam step_t S_REPLY   = 4'd5;
  localparam step_t S_INS_A   = 4'd6;
  localparam step_t S_INS_B   = 4'd7;
  localparam step_t S_INS_C   = 4'd8;
  localparam step_t S_DEL_A   = 4'd9;
  localparam step_t S_DEL_B   = 4'd10;
  localparam step_t S_OUT     = 4'd11;

  // take: request accepted here; give: result shown here;
  // jump to target when cond holds, else hold or advance
  typedef struct packed {
    logic  take;
    logic  give;
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic clr_last;
    logic advance;
    logic ins_ok;
    logic del_ok;
  } dp_flags_t;

  localparam uword_t UCODE [NUM_STEPS] = '{
    '{1'b0, 1'b0, OP_CLEAR, JC_CLR_LAST, 1'b1, S_IDLE},   // S_INIT
    '{1'b1, 1'b0, OP_LOAD,  JC_ACCEPT,   1'b1, S_WALK},   // S_IDLE
    '{1'b0, 1'b0, OP_WALK,  JC_ADVANCE,  1'b0, S_WALK},   // S_WALK
    '{1'b0, 1'b0, OP_NONE,  JC_INS_OK,   1'b0, S_INS_A},  // S_CHK_INS
    '{1'b0, 1'b0, OP_NONE,  JC_DEL_OK,   1'b0, S_DEL_A},  // S_CHK_DEL
    '{1'b0, 1'b0, OP_REPLY, JC_ALWAYS,   1'b0, S_OUT},    // S_REPLY
    '{1'b0, 1'b0, OP_INS_A, JC_NEVER,    1'b0, S_INS_B},  // S_INS_A
    '{1'b0, 1'b0, OP_INS_B, JC_NEVER,    1'b0, S_INS_C},  // S_INS_B
    '{1'b0, 1'b0, OP_INS_C, JC_ALWAYS,   1'b0, S_OUT},    // S_INS_C
    '{1'b0, 1'b0, OP_DEL_A, JC_NEVER,    1'b0, S_DEL_B},  // S_DEL_A
    '{1'b0, 1'b0, OP_DEL_B, JC_NEVER,    1'b0, S_OUT},    // S_DEL_B
    '{1'b0, 1'b1, OP_NONE,  JC_TAKEN,    1'b1, S_IDLE}    // S_OUT
  };

endpackage

@@ rtl/slfl_seq.sv @@
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on slfl_pkg.
module slfl_seq import slfl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  input  dp_flags_t flags,
  output uword_t    uw
);

  step_t step;
  step_t step_next;
  logic  jump;

  assign uw = UCODE[step];

  always_comb begin
    unique case (uw.cond)
      JC_ALWAYS:   jump = 1'b1;
      JC_NEVER:    jump = 1'b0;
      JC_CLR_LAST: jump = flags.clr_last;
      JC_ACCEPT:   jump = in_valid && uw.take;
      JC_ADVANCE:  jump = flags.advance;
      JC_INS_OK:   jump = flags.ins_ok;
      JC_DEL_OK:   jump = flags.del_ok;
      JC_TAKEN:    jump = out_ready && uw.give;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    priority if (jump) begin
      step_next = uw.target;
    end else if (uw.hold) begin
      step_next = step;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_INIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ rtl/slfl_dpath.sv @@
// Datapath: key and link memories, list and free heads, walk registers, result.
// Depends on slfl_pkg; driven by the control word of slfl_seq.
module slfl_dpath import slfl_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  uword_t                   uw,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [KEY_W-1:0]  key,
  output dp_flags_t                flags,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        slot,
  output logic [COUNT_W-1:0]       count
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  typedef logic [LW-1:0] link_t;
  typedef logic [IW-1:0] idx_t;

  localparam link_t NIL = LW'(SLOTS);

  logic [KEY_W-1:0] key_mem  [SLOTS];
  link_t            link_mem [SLOTS];

  idx_t                    rd_addr;
  logic signed [KEY_W-1:0] key_rd;
  link_t                   link_rd;
  logic                    link_we;
  idx_t                    link_wa;
  link_t                   link_wd;
  logic                    key_we;

  link_t head;
  link_t free_head;
  link_t cnt;
  link_t steps;

  link_t                   cur;
  link_t                   prev;
  link_t                   at_link;
  logic [CMD_W-1:0]        cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic                    hit;
  logic [STATUS_W-1:0]     res_status;
  idx_t                    res_slot;

  logic cur_live;
  logic prev_live;
  logic free_live;
  logic in_range;
  logic advance;
  logic found;

  assign cur_live  = cur < NIL;
  assign prev_live = prev < NIL;
  assign free_live = free_head < NIL;
  assign in_range  = steps < NIL;
  assign advance   = cur_live && in_range && (key_rd < key_q);
  assign found     = cur_live && in_range && (key_rd == key_q);

  assign flags.clr_last = steps == LW'(SLOTS - 1);
  assign flags.advance  = advance;
  assign flags.ins_ok   = (cmd_q == CMD_INSERT) && !hit && (cnt < NIL) && free_live;
  assign flags.del_ok   = (cmd_q == CMD_DELETE) && hit;

  assign key_we = uw.op == OP_INS_A;

  always_comb begin
    unique case (uw.op)
      OP_LOAD:  rd_addr = head[IW-1:0];
      OP_WALK:  rd_addr = link_rd[IW-1:0];
      OP_INS_A: rd_addr = free_head[IW-1:0];
      default:  rd_addr = cur[IW-1:0];
    endcase
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = steps[IW-1:0];
    link_wd = steps + link_t'(1);
    unique case (uw.op)
      OP_CLEAR: begin
        link_we = 1'b1;
      end
      OP_INS_B: begin
        link_we = 1'b1;
        link_wa = res_slot;
        link_wd = cur;
      end
      OP_INS_C: begin
        link_we = prev_live;
        link_wa = prev[IW-1:0];
        link_wd = LW'(res_slot);
      end
      OP_DEL_A: begin
        link_we = prev_live;
        link_wa = prev[IW-1:0];
        link_wd = at_link;
      end
      OP_DEL_B: begin
        link_we = 1'b1;
        link_wa = cur[IW-1:0];
        link_wd = free_head;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (key_we) begin
      key_mem[free_head[IW-1:0]] <= key_q;
    end
    key_rd  <= key_mem[rd_addr];
    link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      free_head <= '0;
      cnt       <= '0;
      steps     <= '0;
    end else begin
      unique case (uw.op)
        OP_CLEAR: steps <= steps + link_t'(1);
        OP_LOAD:  steps <= '0;
        OP_WALK: begin
          if (advance) begin
            steps <= steps + link_t'(1);
          end
        end
        OP_INS_B: free_head <= link_rd;
        OP_INS_C: begin
          if (!prev_live) begin
            head <= LW'(res_slot);
          end
          cnt <= cnt + link_t'(1);
        end
        OP_DEL_A: begin
          if (!prev_live) begin
            head <= at_link;
          end
        end
        OP_DEL_B: begin
          free_head <= cur;
          if (cnt != '0) begin
            cnt <= cnt - link_t'(1);
          end
        end
        default: begin
          steps <= steps;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LOAD: begin
        cmd_q <= command;
        key_q <= key;
        cur   <= head;
        prev  <= NIL;
      end
      OP_WALK: begin
        if (advance) begin
          prev <= cur;
          cur  <= link_rd;
        end else begin
          hit     <= found;
          at_link <= link_rd;
          if (!in_range) begin
            cur <= NIL;
          end
        end
      end
      OP_REPLY: begin
        if ((cmd_q == CMD_SEARCH) && hit) begin
          res_status <= ST_OK;
          res_slot   <= cur[IW-1:0];
        end else if ((cmd_q == CMD_INSERT) && !hit) begin
          res_status <= ST_FULL;
          res_slot   <= '0;
        end else begin
          res_status <= ST_MISS;
          res_slot   <= '0;
        end
      end
      OP_INS_A: begin
        res_status <= ST_OK;
        res_slot   <= free_head[IW-1:0];
      end
      OP_DEL_B: begin
        res_status <= ST_OK;
        res_slot   <= cur[IW-1:0];
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  assign status = res_status;
  assign slot   = SLOT_W'(res_slot);
  assign count  = COUNT_W'(cnt);

endmodule

@@ rtl/sorted_list_free_list_engine.sv @@
// Sorted list engine: top level, sequencer plus datapath, assertions.
// A request walks the list from its head, one link read per key below the request key (at most SLOTS
// keys); a successful insert or delete then updates the links before the result is shown.
// One request at a time: a new request is accepted only after the last result has been taken.
// Reset: link memory clearing pass over all SLOTS links with in_ready low.
// Depends on slfl_pkg, slfl_seq, slfl_dpath and the macros header.
`include "sorted_list_free_list_engine_macros.svh"

module sorted_list_free_list_engine import slfl_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        command,
  input  logic signed [KEY_W-1:0] key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [SLOT_W-1:0]       slot,
  output logic [COUNT_W-1:0]      count
);

  uword_t    uw;
  dp_flags_t flags;

  slfl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .uw        (uw)
  );

  slfl_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .uw      (uw),
    .command (command),
    .key     (key),
    .flags   (flags),
    .status  (status),
    .slot    (slot),
    .count   (count)
  );

  assign in_ready  = uw.take;
  assign out_valid = uw.give;

  `SLFL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `SLFL_ASSERT_NEXT(a_idle_after_take, clk, rst, out_valid && out_ready, in_ready)
  `SLFL_ASSERT_IMPL(a_one_side, clk, rst, in_ready, !out_valid)
  `SLFL_ASSERT_IMPL(a_slot_zero_on_fail, clk, rst, out_valid && (status != ST_OK), slot == '0)

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the sorted list engine: directed, full-store and random request
// streams, with random stalls on both handshakes and a long stall on the result handshake.
// Depends on slfl_pkg and the sorted_list_free_list_engine top level.
`timescale 1ns / 1ps

module tb;
  import slfl_pkg::*;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [6:0] LINK_NIL = 7'(SLOTS);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE = 80;
  localparam int MAX_GAP = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        command = '0;
  logic signed [KEY_W-1:0] key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_W-1:0]       slot;
  logic [COUNT_W-1:0]      count;

  // list state mirrored by the predictor
  logic signed [KEY_W-1:0] m_keys [SLOTS];
  logic [6:0]              m_links [SLOTS];
  logic [6:0]              m_head;
  logic [6:0]              m_free;
  logic [6:0]              m_held;

  list_result_t            expected_results [$];
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      hold_request = 0;
  int                      hold_left = 0;
  int                      fail_count = 0;
  int                      cycle_count = 0;

  sorted_list_free_list_engine #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot      (slot),
    .count     (count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void reset_list_model();
    for (int i = 0; i < SLOTS; i++) begin
      m_keys[i] = '0;
      m_links[i] = 7'(i + 1);
    end
    m_head = LINK_NIL;
    m_free = '0;
    m_held = '0;
  endfunction

  function automatic list_result_t predict_list_op(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [KEY_W-1:0] k);
    list_result_t r;
    logic [6:0] cur;
    logic [6:0] prev;
    logic [6:0] s;
    int steps;
    logic hit;
    r.status = ST_MISS;
    r.slot = '0;
    cur = m_head;
    prev = LINK_NIL;
    steps = 0;
    while (cur < LINK_NIL && steps < SLOTS && m_keys[cur[IDX_W-1:0]] < k) begin
      prev = cur;
      cur = m_links[cur[IDX_W-1:0]];
      steps++;
    end
    if (steps >= SLOTS) cur = LINK_NIL;
    hit = (cur < LINK_NIL) && (m_keys[cur[IDX_W-1:0]] == k);
    case (cmd)
      CMD_SEARCH: begin
        if (hit) begin
          r.status = ST_OK;
          r.slot = cur[SLOT_W-1:0];
        end
      end
      CMD_INSERT: begin
        if (hit) begin
          r.status = ST_MISS;
        end else if (m_held >= SLOTS || m_free >= LINK_NIL) begin
          r.status = ST_FULL;
        end else begin
          s = m_free;
          m_free = m_links[s[IDX_W-1:0]];
          m_links[s[IDX_W-1:0]] = cur;
          m_keys[s[IDX_W-1:0]] = k;
          if (prev < LINK_NIL) m_links[prev[IDX_W-1:0]] = s;
          else m_head = s;
          m_held++;
          r.status = ST_OK;
          r.slot = s[SLOT_W-1:0];
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          if (prev < LINK_NIL) m_links[prev[IDX_W-1:0]] = m_links[cur[IDX_W-1:0]];
          else m_head = m_links[cur[IDX_W-1:0]];
          m_links[cur[IDX_W-1:0]] = m_free;
          m_free = cur;
          if (m_held > 0) m_held--;
          r.status = ST_OK;
          r.slot = cur[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    r.count = m_held;
    return r;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] k);
    int gap;
    bit took;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    key <= k;
    do begin
      @(negedge clk);
      took = (in_ready === 1'b1);
      @(posedge clk);
    end while (!took);
    expected_results.push_back(predict_list_op(cmd, k));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom;
    if (r < 10) return KEY_MIN;
    if (r < 12) return KEY_MAX;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input int ins_w, input int del_w);
    int r;
    r = $urandom_range(99);
    if (r < 3) return CMD_UNUSED;
    if (r < 3 + ins_w) return CMD_INSERT;
    if (r < 3 + ins_w + del_w) return CMD_DELETE;
    return CMD_SEARCH;
  endfunction

  task automatic test_directed();
    send_request(CMD_SEARCH, 32'sd0);
    send_request(CMD_DELETE, 32'sd0);
    send_request(CMD_UNUSED, 32'sd0);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_INSERT, KEY_MIN);
    send_request(CMD_INSERT, KEY_MAX);
    send_request(CMD_INSERT, -32'sd1);
    send_request(CMD_INSERT, 32'sd1);
    send_request(CMD_SEARCH, KEY_MIN);
    send_request(CMD_SEARCH, KEY_MAX);
    send_request(CMD_SEARCH, 32'sd1);
    send_request(CMD_SEARCH, 32'sd2);
    send_request(CMD_DELETE, 32'sd1);
    send_request(CMD_DELETE, KEY_MIN);
    send_request(CMD_DELETE, KEY_MAX);
    send_request(CMD_DELETE, KEY_MAX);
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'shAAAA_AAAA);
    send_request(CMD_INSERT, 32'sh5555_5555);
    send_request(CMD_UNUSED, 32'shFFFF_FFFF);
    send_request(CMD_SEARCH, 32'sh5555_5555);
    wait_all_results();
  endtask

  task automatic test_full_store();
    logic signed [KEY_W-1:0] k;
    for (int i = 0; i < SLOTS && m_held < SLOTS; i++) begin
      k = ((i * 37) % SLOTS) * 1000 - 30000;
      send_request(CMD_INSERT, k);
    end
    send_request(CMD_INSERT, 32'sd123456789);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_SEARCH, 32'sd33000);
    send_request(CMD_SEARCH, KEY_MAX);
    send_request(CMD_DELETE, KEY_MAX);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      k = ((i * 29) % SLOTS) * 1000 - 30000;
      send_request(CMD_DELETE, k);
    end
    while (m_held > 0) send_request(CMD_DELETE, m_keys[m_head[IDX_W-1:0]]);
    send_request(CMD_SEARCH, 32'sd0);
    wait_all_results();
  endtask

  task automatic run_random_traffic(input int n_fill, input int n_mixed, input int n_drain);
    for (int i = 0; i < n_fill; i++) send_request(pick_command(65, 12), pick_key());
    for (int i = 0; i < n_mixed; i++) send_request(pick_command(40, 27), pick_key());
    for (int i = 0; i < n_drain; i++) send_request(pick_command(12, 65), pick_key());
    wait_all_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 15; i++) send_request(pick_command(50, 20), pick_key());
    wait_all_results();
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    list_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, slot %0d, count %0d", status, slot, count);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status);
          fail_count++;
        end
        if (slot !== exp_r.slot) begin
          $error("slot: expected %0d, actual %0d", exp_r.slot, slot);
          fail_count++;
        end
        if (count !== exp_r.count) begin
          $error("count: expected %0d, actual %0d", exp_r.count, count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reset_list_model();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_store();

    send_idle_pct = 21;
    recv_idle_pct = 66;
    run_random_traffic(130, 90, 130);

    test_backpressure();

    send_idle_pct = 66;
    recv_idle_pct = 21;
    run_random_traffic(130, 90, 130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(130, 90, 130);

    repeat (SLOTS + 16) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
